FILE: hw/rtl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg: shared types and constants
// Function codes, register indexes, result kinds and operation codes of the
// shared arithmetic unit for the delayed play timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned SOUND_W    = 16;
  localparam int unsigned DELAY_W    = 32;
  localparam int unsigned VOL_W      = 16;
  localparam int unsigned NOW_W      = 48;
  localparam int unsigned GAP_W      = 32;
  localparam int unsigned PVOL_W     = VOL_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PLAY    = 3'd0,
    FN_DELAY   = 3'd1,
    FN_PRV_VOL = 3'd2,
    FN_PRV_END = 3'd3,
    FN_TICK    = 3'd4
  } func_t;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VOLUME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_GAP       = 1'd1;

  localparam logic KIND_PLAY = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dpt_if.sv
// ----------------------------------------------------------------------------
// dpt_if: request and result channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpt_req_if;
  logic                           valid;
  logic                           ready;
  logic [dpt_pkg::FUNC_W-1:0]     func;
  logic [dpt_pkg::SOUND_W-1:0]    sound_id;
  logic [dpt_pkg::DELAY_W-1:0]    delay;
  logic [dpt_pkg::VOL_W-1:0]      volume;
  logic                           use_default;
  logic [dpt_pkg::NOW_W-1:0]      now;

  modport source (output valid, func, sound_id, delay, volume, use_default, now,
                  input ready);
  modport sink   (input valid, func, sound_id, delay, volume, use_default, now,
                  output ready);
endinterface

interface dpt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [dpt_pkg::SOUND_W-1:0]    sound_id_res;
  logic [dpt_pkg::VOL_W-1:0]      volume_res;
  logic                           last;

  modport source (output valid, kind, sound_id_res, volume_res, last, input ready);
  modport sink   (input valid, kind, sound_id_res, volume_res, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dpt_alu.sv
// ----------------------------------------------------------------------------
// dpt_alu: shared time arithmetic unit
// One adder/subtractor and one unsigned compare, reused by every sequencer
// step that works on times, gaps or delays.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_alu #(
  parameter int unsigned W = 48
) (
  input  var dpt_pkg::alu_op_t op,
  input  wire logic [W-1:0]    a,
  input  wire logic [W-1:0]    b,
  output logic      [W-1:0]    res,
  output logic                 ge
);

  always_comb begin
    case (op)
      dpt_pkg::ALU_SUB: res = a - b;
      default:          res = a + b;
    endcase
  end

  assign ge = (a >= b);

endmodule

`default_nettype wire

FILE: hw/rtl/dpt_slot_mem.sv
// ----------------------------------------------------------------------------
// dpt_slot_mem: slot payload store
// Sound, packed volume and due time per slot; one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned TW    = 48
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [IDX_W-1:0]              waddr,
  input  wire logic [dpt_pkg::SOUND_W-1:0]   wsound,
  input  wire logic [dpt_pkg::PVOL_W-1:0]    wvol,
  input  wire logic [TW-1:0]                 wdue,
  input  wire logic [IDX_W-1:0]              raddr,
  output logic      [dpt_pkg::SOUND_W-1:0]   rsound,
  output logic      [dpt_pkg::PVOL_W-1:0]    rvol,
  output logic      [TW-1:0]                 rdue
);

  logic [dpt_pkg::SOUND_W-1:0] mem_sound [DEPTH];
  logic [dpt_pkg::PVOL_W-1:0]  mem_vol   [DEPTH];
  logic [TW-1:0]               mem_due   [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_sound[waddr] <= wsound;
      mem_vol[waddr]   <= wvol;
      mem_due[waddr]   <= wdue;
    end
    rsound <= mem_sound[raddr];
    rvol   <= mem_vol[raddr];
    rdue   <= mem_due[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/delayed_play_timer_table.sv
// ----------------------------------------------------------------------------
// delayed_play_timer_table: delayed play table with throttled preview
// Requests enter on req, play and drop beats leave on rsp. A small sequencer
// drives one shared add/compare unit over the slot store.
//
// req is ready only when the sequencer is idle. Steps per request:
//   immediate play, preview end : accept, flush
//   delayed play                : accept, then the free-slot scan, one step
//                                 per occupied slot passed, then flush on a drop
//   preview volume change       : accept, difference, compare, then
//                                 arm or flush when needed
//   tick                        : accept, one compare per slot through the
//                                 shared unit, then the armed preview, flush
//   unused codes                : accept only
// Results of one request leave as a burst of beats, the final one with last
// set; one beat is held back so last is known. A stalled rsp holds the
// sequencer at its next beat; the output register frees the block to take
// the next request while the final beat waits.
// Reset (synchronous, rst high) empties the table, disarms the preview,
// clears the last preview time and loads default_volume 65535, play_gap
// 100000. Configuration writes are taken on any cycle with cfg_we high and rst low.
// ----------------------------------------------------------------------------
`default_nettype none

module delayed_play_timer_table #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  dpt_req_if.sink                                req,
  dpt_rsp_if.source                              rsp,
  input  wire logic                              cfg_we,
  input  wire logic [dpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dpt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AW    = (TIME_BITS > dpt_pkg::GAP_W) ? TIME_BITS
                                                                : dpt_pkg::GAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DLY_SCAN = 8'b0000_0010,
    S_PRV_DIFF = 8'b0000_0100,
    S_PRV_CMP  = 8'b0000_1000,
    S_PRV_ARM  = 8'b0001_0000,
    S_TICK_CMP = 8'b0010_0000,
    S_TICK_PRV = 8'b0100_0000,
    S_FLUSH    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  logic [dpt_pkg::VOL_W-1:0] default_volume;
  logic [dpt_pkg::GAP_W-1:0] play_gap;

  logic [dpt_pkg::SOUND_W-1:0] it_sound;
  logic [dpt_pkg::DELAY_W-1:0] it_delay;
  logic [dpt_pkg::PVOL_W-1:0]  it_vol;
  logic [TIME_BITS-1:0]        it_now;

  logic [SLOTS-1:0] slot_valid, slot_valid_next;

  logic                         armed, armed_next;
  logic [TIME_BITS-1:0]         prv_due, prv_due_next;
  logic [dpt_pkg::PVOL_W-1:0]   prv_vol, prv_vol_next;
  logic [dpt_pkg::SOUND_W-1:0]  prv_sound, prv_sound_next;
  logic [TIME_BITS-1:0]         last_prv, last_prv_next;
  logic [TIME_BITS-1:0]         diff, diff_next;

  logic                         pend_valid, pend_valid_next;
  logic                         pend_kind, pend_kind_next;
  logic [dpt_pkg::SOUND_W-1:0]  pend_sound, pend_sound_next;
  logic [dpt_pkg::VOL_W-1:0]    pend_vol, pend_vol_next;

  logic                         o_valid;
  logic                         o_kind;
  logic [dpt_pkg::SOUND_W-1:0]  o_sound;
  logic [dpt_pkg::VOL_W-1:0]    o_vol;
  logic                         o_last;
  logic                         out_load, out_last;
  logic                         out_free, can_emit;

  dpt_pkg::alu_op_t alu_op;
  logic [AW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_ge;

  logic                         mem_we;
  logic [dpt_pkg::SOUND_W-1:0]  rd_sound;
  logic [dpt_pkg::PVOL_W-1:0]   rd_vol;
  logic [TIME_BITS-1:0]         rd_due;

  logic                         accept;
  logic [dpt_pkg::PVOL_W-1:0]   req_pvol;

  function automatic logic [dpt_pkg::VOL_W-1:0] resolve(
    input logic [dpt_pkg::PVOL_W-1:0] pv,
    input logic [dpt_pkg::VOL_W-1:0]  dv
  );
    return pv[dpt_pkg::VOL_W] ? dv : pv[dpt_pkg::VOL_W-1:0];
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign req_pvol  = {req.use_default, req.volume};
  assign out_free  = !o_valid || rsp.ready;
  assign can_emit  = !pend_valid || out_free;

  dpt_alu #(.W(AW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  dpt_slot_mem #(.DEPTH(SLOTS), .IDX_W(IDX_W), .TW(TIME_BITS)) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (idx),
    .wsound (it_sound),
    .wvol   (it_vol),
    .wdue   (alu_res[TIME_BITS-1:0]),
    .raddr  (idx_next),
    .rsound (rd_sound),
    .rvol   (rd_vol),
    .rdue   (rd_due)
  );

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    slot_valid_next = slot_valid;
    armed_next      = armed;
    prv_due_next    = prv_due;
    prv_vol_next    = prv_vol;
    prv_sound_next  = prv_sound;
    last_prv_next   = last_prv;
    diff_next       = diff;
    pend_valid_next = pend_valid;
    pend_kind_next  = pend_kind;
    pend_sound_next = pend_sound;
    pend_vol_next   = pend_vol;
    out_load        = 1'b0;
    out_last        = 1'b0;
    mem_we          = 1'b0;
    alu_op          = dpt_pkg::ALU_ADD;
    alu_a           = AW'(it_now);
    alu_b           = AW'(it_delay);

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          idx_next = '0;
          case (dpt_pkg::func_t'(req.func))
            dpt_pkg::FN_PLAY: begin
              pend_valid_next = 1'b1;
              pend_kind_next  = dpt_pkg::KIND_PLAY;
              pend_sound_next = req.sound_id;
              pend_vol_next   = resolve(req_pvol, default_volume);
              state_next      = S_FLUSH;
            end
            dpt_pkg::FN_DELAY:   state_next = S_DLY_SCAN;
            dpt_pkg::FN_PRV_VOL: state_next = S_PRV_DIFF;
            dpt_pkg::FN_PRV_END: begin
              pend_valid_next = 1'b1;
              pend_kind_next  = dpt_pkg::KIND_PLAY;
              pend_sound_next = req.sound_id;
              pend_vol_next   = default_volume;
              armed_next      = 1'b0;
              state_next      = S_FLUSH;
            end
            dpt_pkg::FN_TICK:    state_next = S_TICK_CMP;
            default:             state_next = S_IDLE;
          endcase
        end
      end

      S_DLY_SCAN: begin
        if (!slot_valid[idx]) begin
          mem_we               = 1'b1;
          slot_valid_next[idx] = 1'b1;
          state_next           = S_IDLE;
        end else if (idx == LAST_IDX) begin
          pend_valid_next = 1'b1;
          pend_kind_next  = dpt_pkg::KIND_DROP;
          pend_sound_next = it_sound;
          pend_vol_next   = '0;
          state_next      = S_FLUSH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      S_PRV_DIFF: begin
        alu_op       = dpt_pkg::ALU_SUB;
        alu_b        = AW'(last_prv);
        diff_next    = alu_res[TIME_BITS-1:0];
        prv_vol_next = it_vol;
        state_next   = S_PRV_CMP;
      end

      S_PRV_CMP: begin
        alu_a = AW'(diff);
        alu_b = AW'(play_gap);
        if (alu_ge) begin
          last_prv_next   = it_now;
          pend_valid_next = 1'b1;
          pend_kind_next  = dpt_pkg::KIND_PLAY;
          pend_sound_next = it_sound;
          pend_vol_next   = default_volume;
          state_next      = S_FLUSH;
        end else if (!armed) begin
          state_next = S_PRV_ARM;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_PRV_ARM: begin
        alu_a          = AW'(last_prv);
        alu_b          = AW'(play_gap);
        armed_next     = 1'b1;
        prv_due_next   = alu_res[TIME_BITS-1:0];
        prv_sound_next = it_sound;
        state_next     = S_IDLE;
      end

      S_TICK_CMP: begin
        alu_b = AW'(rd_due);
        if (slot_valid[idx] && alu_ge && !can_emit) begin
          state_next = S_TICK_CMP;
        end else begin
          if (slot_valid[idx] && alu_ge) begin
            out_load             = pend_valid;
            pend_valid_next      = 1'b1;
            pend_kind_next       = dpt_pkg::KIND_PLAY;
            pend_sound_next      = rd_sound;
            pend_vol_next        = resolve(rd_vol, default_volume);
            slot_valid_next[idx] = 1'b0;
          end
          if (idx == LAST_IDX) begin
            state_next = S_TICK_PRV;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      S_TICK_PRV: begin
        alu_b = AW'(prv_due);
        if (armed && alu_ge) begin
          if (can_emit) begin
            out_load        = pend_valid;
            pend_valid_next = 1'b1;
            pend_kind_next  = dpt_pkg::KIND_PLAY;
            pend_sound_next = prv_sound;
            pend_vol_next   = resolve(prv_vol, default_volume);
            armed_next      = 1'b0;
            state_next      = S_FLUSH;
          end
        end else begin
          state_next = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load        = 1'b1;
          out_last        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slot_valid     <= '0;
      armed          <= 1'b0;
      prv_due        <= '0;
      prv_vol        <= '0;
      prv_sound      <= '0;
      last_prv       <= '0;
      pend_valid     <= 1'b0;
      o_valid        <= 1'b0;
      default_volume <= 16'd65535;
      play_gap       <= 32'd100000;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      armed      <= armed_next;
      prv_due    <= prv_due_next;
      prv_vol    <= prv_vol_next;
      prv_sound  <= prv_sound_next;
      last_prv   <= last_prv_next;
      pend_valid <= pend_valid_next;
      if (out_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          dpt_pkg::REG_DEFAULT_VOLUME: default_volume <= cfg_wdata[dpt_pkg::VOL_W-1:0];
          dpt_pkg::REG_PLAY_GAP:       play_gap       <= cfg_wdata;
          default:                     play_gap       <= play_gap;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    diff       <= diff_next;
    pend_kind  <= pend_kind_next;
    pend_sound <= pend_sound_next;
    pend_vol   <= pend_vol_next;
    if (accept) begin
      it_sound <= req.sound_id;
      it_delay <= req.delay;
      it_vol   <= req_pvol;
      it_now   <= TIME_BITS'(req.now);
    end
    if (out_load) begin
      o_kind  <= pend_kind;
      o_sound <= pend_sound;
      o_vol   <= pend_vol;
      o_last  <= out_last;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.kind         = o_kind;
  assign rsp.sound_id_res = o_sound;
  assign rsp.volume_res   = o_vol;
  assign rsp.last         = o_last;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !pend_valid)
    else $error("pending beat left over while idle");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == dpt_pkg::FN_TICK) |=> (state == S_TICK_CMP && idx == '0))
    else $error("tick did not start the slot scan at slot zero");

  a_slots_fill_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state != S_DLY_SCAN) |=> ($countones(slot_valid) <= $past($countones(slot_valid))))
    else $error("slot taken outside the free-slot scan");

  a_arm_from_arm_step: assert property (@(posedge clk) disable iff (rst)
    $rose(armed) |-> ($past(state) == S_PRV_ARM))
    else $error("preview armed outside the arm step");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten while its beat is stalled");
`endif

endmodule

`default_nettype wire

FILE: verif/delayed_play_timer_table_test.sv
// ----------------------------------------------------------------------------
// delayed_play_timer_table_test: self-checking regression
// Drives request beats, tracks the delay table and the throttled preview in a
// scoreboard, and checks every play or drop beat in order. Covers settings
// extremes and idle, stall and mixed flow-control phases.
// ----------------------------------------------------------------------------

package dpt_test_pkg;
  import dpt_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [SOUND_W-1:0] sound_id;
    logic [DELAY_W-1:0] delay;
    logic [VOL_W-1:0]   volume;
    logic               use_default;
    logic [NOW_W-1:0]   now;
  } play_req_t;

  typedef struct packed {
    logic               kind;
    logic [SOUND_W-1:0] sound_id;
    logic [VOL_W-1:0]   volume;
    logic               last;
  } play_beat_t;

  function automatic play_beat_t make_beat(logic kind, logic [SOUND_W-1:0] snd,
                                           logic [VOL_W-1:0] vol, logic last);
    play_beat_t b;
    b.kind = kind;
    b.sound_id = snd;
    b.volume = vol;
    b.last = last;
    return b;
  endfunction

  class play_scoreboard;
    logic [VOL_W-1:0]   default_volume;
    logic [GAP_W-1:0]   play_gap;
    bit                 slot_busy [SLOTS];
    logic [SOUND_W-1:0] slot_sound [SLOTS];
    logic [NOW_W-1:0]   slot_due [SLOTS];
    logic [PVOL_W-1:0]  slot_vol [SLOTS];
    logic [NOW_W-1:0]   last_preview;
    bit                 armed;
    logic [NOW_W-1:0]   preview_due;
    logic [PVOL_W-1:0]  preview_vol;
    logic [SOUND_W-1:0] preview_sound;
    play_beat_t         awaited[$];
    int unsigned        errors;

    function new();
      default_volume = 16'hFFFF;
      play_gap = 32'd100000;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      last_preview = '0;
      armed = 1'b0;
      preview_due = '0;
      preview_vol = '0;
      preview_sound = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_DEFAULT_VOLUME) default_volume = val[VOL_W-1:0];
      else if (idx == REG_PLAY_GAP) play_gap = val[GAP_W-1:0];
    endfunction

    function logic [VOL_W-1:0] resolve(logic [PVOL_W-1:0] pv);
      return pv[VOL_W] ? default_volume : pv[VOL_W-1:0];
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function void note_request(play_req_t it);
      play_beat_t        caused[$];
      logic [PVOL_W-1:0] pv;
      logic [NOW_W-1:0]  elapsed;
      int                free_slot;
      pv = {it.use_default, it.volume};
      free_slot = -1;
      case (it.func)
        FN_PLAY: caused.push_back(make_beat(KIND_PLAY, it.sound_id, resolve(pv), 1'b0));
        FN_DELAY: begin
          foreach (slot_busy[i]) if (!slot_busy[i] && free_slot < 0) free_slot = i;
          if (free_slot < 0) begin
            caused.push_back(make_beat(KIND_DROP, it.sound_id, '0, 1'b0));
          end else begin
            slot_busy[free_slot] = 1'b1;
            slot_sound[free_slot] = it.sound_id;
            slot_due[free_slot] = it.now + NOW_W'(it.delay);
            slot_vol[free_slot] = pv;
          end
        end
        FN_PRV_VOL: begin
          elapsed = it.now - last_preview;
          preview_vol = pv;
          if (elapsed >= NOW_W'(play_gap)) begin
            last_preview = it.now;
            caused.push_back(make_beat(KIND_PLAY, it.sound_id, default_volume, 1'b0));
          end else if (!armed) begin
            armed = 1'b1;
            preview_due = last_preview + NOW_W'(play_gap);
            preview_sound = it.sound_id;
          end
        end
        FN_PRV_END: begin
          caused.push_back(make_beat(KIND_PLAY, it.sound_id, default_volume, 1'b0));
          armed = 1'b0;
        end
        FN_TICK: begin
          foreach (slot_busy[i]) begin
            if (slot_busy[i] && it.now >= slot_due[i]) begin
              caused.push_back(make_beat(KIND_PLAY, slot_sound[i], resolve(slot_vol[i]), 1'b0));
              slot_busy[i] = 1'b0;
            end
          end
          if (armed && it.now >= preview_due) begin
            armed = 1'b0;
            caused.push_back(make_beat(KIND_PLAY, preview_sound, resolve(preview_vol), 1'b0));
          end
        end
        default: ;
      endcase
      if (caused.size() != 0) caused[caused.size()-1].last = 1'b1;
      foreach (caused[i]) awaited.push_back(caused[i]);
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_beat(play_beat_t got);
      play_beat_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual kind %0d sound %h vol %h last %0d",
                 $time, got.kind, got.sound_id, got.volume, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got.kind != want.kind) report("kind", want.kind, got.kind);
      if (got.sound_id != want.sound_id) report("sound_id_res", want.sound_id, got.sound_id);
      if (got.volume != want.volume) report("volume_res", want.volume, got.volume);
      if (got.last != want.last) report("last", want.last, got.last);
    endfunction
  endclass

endpackage

module delayed_play_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dpt_pkg::*;
  import dpt_test_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam logic [NOW_W-1:0] TIME_TOP = '1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dpt_req_if req();
  dpt_rsp_if rsp();

  play_scoreboard   book = new();
  int unsigned      src_idle_pct = 0;
  int unsigned      sink_stall_pct = 0;
  int unsigned      cycle_count;
  logic [NOW_W-1:0] tick_now = '0;

  delayed_play_timer_table dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clk);
    $display("delayed_play_timer_table regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      book.check_beat(make_beat(rsp.kind, rsp.sound_id_res, rsp.volume_res, rsp.last));
    rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic play_req_t make_req(logic [FUNC_W-1:0] func, logic [SOUND_W-1:0] snd,
                                         logic [DELAY_W-1:0] delay, logic [VOL_W-1:0] vol,
                                         logic use_def, logic [NOW_W-1:0] stamp);
    play_req_t it;
    it.func = func;
    it.sound_id = snd;
    it.delay = delay;
    it.volume = vol;
    it.use_default = use_def;
    it.now = stamp;
    return it;
  endfunction

  function automatic play_req_t random_request();
    play_req_t   it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 14) it.func = FN_PLAY;
    else if (pick < 46) it.func = FN_DELAY;
    else if (pick < 60) it.func = FN_PRV_VOL;
    else if (pick < 65) it.func = FN_PRV_END;
    else if (pick < 97) it.func = FN_TICK;
    else it.func = FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
    it.sound_id = SOUND_W'($urandom);
    it.volume = VOL_W'($urandom);
    it.use_default = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 75) it.delay = $urandom_range(300);
    else if (pick < 95) it.delay = $urandom;
    else it.delay = '1;
    pick = $urandom_range(99);
    if (pick < 60) tick_now += $urandom_range(20);
    else if (pick < 95) tick_now += $urandom_range(400);
    else tick_now += $urandom;
    it.now = tick_now;
    return it;
  endfunction

  // valid stays high across back-to-back beats; it only drops for a gap
  task automatic send_request(input play_req_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.func        <= it.func;
    req.sound_id    <= it.sound_id;
    req.delay       <= it.delay;
    req.volume      <= it.volume;
    req.use_default <= it.use_default;
    req.now         <= it.now;
    do @(posedge clk); while (!req.ready);
    book.note_request(it);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (book.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] vol, input logic [CFG_DATA_W-1:0] gap);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEFAULT_VOLUME;
    cfg_wdata <= vol;
    @(posedge clk);
    book.write_reg(REG_DEFAULT_VOLUME, vol);
    cfg_index <= REG_PLAY_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    book.write_reg(REG_PLAY_GAP, gap);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send_request(make_req(FN_PLAY, 16'h0000, 32'h0, 16'h0000, 1'b0, 48'd0));
    send_request(make_req(FN_PLAY, 16'hFFFF, '1, 16'hFFFF, 1'b1, 48'd0));
    send_request(make_req(FN_SPARE_HI, 16'hFFFF, '1, 16'hFFFF, 1'b1, 48'd0));
    send_request(make_req(FN_SPARE_LO, 16'h5A5A, 32'd9, 16'h1111, 1'b0, 48'd0));
    // preview: play at once, arm, volume update while armed, end, re-arm
    send_request(make_req(FN_PRV_VOL, 16'h0003, 32'h0, 16'h0100, 1'b0, 48'd60));
    send_request(make_req(FN_PRV_VOL, 16'h0004, 32'h0, 16'h0200, 1'b0, 48'd70));
    send_request(make_req(FN_PRV_VOL, 16'h0005, 32'h0, 16'h0300, 1'b1, 48'd80));
    send_request(make_req(FN_PRV_END, 16'h0008, 32'h0, 16'h0400, 1'b0, 48'd90));
    send_request(make_req(FN_PRV_VOL, 16'h0009, 32'h0, 16'hABCD, 1'b0, 48'd100));
    // fill the table near the top of time so half the due times wrap
    for (int i = 0; i < SLOTS; i++)
      send_request(make_req(FN_DELAY, 16'h0100 + SOUND_W'(i), DELAY_W'(i),
                            VOL_W'(i * 4099), i[0], TIME_TOP - 48'd7));
    send_request(make_req(FN_DELAY, 16'hDEAD, 32'd1, 16'h7777, 1'b0, TIME_TOP - 48'd7));
    send_request(make_req(FN_TICK, 16'h0000, 32'h0, 16'h0000, 1'b0, TIME_TOP));
    send_request(make_req(FN_TICK, 16'h0000, 32'h0, 16'h0000, 1'b0, TIME_TOP));
    send_request(make_req(FN_PRV_VOL, 16'h000A, 32'h0, 16'h0500, 1'b0, 48'd5));
    tick_now = 48'd5;
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    req.valid       <= 1'b0;
    req.func        <= '0;
    req.sound_id    <= '0;
    req.delay       <= '0;
    req.volume      <= '0;
    req.use_default <= 1'b0;
    req.now         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_regs(32'h1234, 32'd50);
    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       set_regs(32'h0000, 32'h0);
        1:       set_regs(32'hFFFF, 32'hFFFF_FFFF);
        2:       set_regs(CFG_DATA_W'($urandom_range(16'hFFFF)), 32'd40);
        4:       set_regs(CFG_DATA_W'($urandom_range(16'hFFFF)), $urandom);
        default: set_regs(CFG_DATA_W'($urandom_range(16'hFFFF)), $urandom_range(600));
      endcase
      src_idle_pct   = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 23 : 0;
      sink_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 23 : 0;
      repeat (PHASE_ITEMS) send_request(random_request());
    end
    drain();

    if (book.errors == 0)
      $display("delayed_play_timer_table regression: pass");
    else
      $display("delayed_play_timer_table regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/dpt_pkg.sv
hw/rtl/dpt_if.sv
hw/rtl/dpt_alu.sv
hw/rtl/dpt_slot_mem.sv
hw/rtl/delayed_play_timer_table.sv
verif/delayed_play_timer_table_test.sv
